FILE: rtl/core/escd_pkg.sv
// Shared types, calendar constants and the month table for the epoch-to-date converter.
// Used by the date channel interface, the civil date pipeline and the top level.
// Depends on nothing.
`default_nettype none

package escd_pkg;

  // Seconds per day factor into a power of two and an odd part: 86400 = 128 * 675.
  localparam int unsigned SECS_PER_DAY = 60 * 60 * 24;
  localparam int unsigned DAY_SHIFT = 7;
  localparam int unsigned DAY_ODD = 675;

  localparam int unsigned SECS_PER_MIN = 60;
  localparam int unsigned MIN_PER_HOUR = 60;

  // Day counts of the proleptic Gregorian calendar.
  localparam int unsigned DAYS_0001_TO_1970 = 719162;
  localparam int unsigned DAYS_PER_400Y = 146097;
  localparam int unsigned DAYS_PER_100Y = 36524;
  localparam int unsigned DAYS_PER_4Y = 1461;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned YEARS_PER_400Y = 400;
  localparam int unsigned YEARS_PER_100Y = 100;
  localparam int unsigned YEARS_PER_4Y = 4;
  localparam int unsigned CENTURY_IN_4Y = 24;

  // Exact reciprocals: (x * RECIP) >> SHIFT equals x / divisor over the stated range.
  // Seconds of day (below 2^17) divided by 60.
  localparam logic [17:0] RECIP_MIN = 18'd139811;
  localparam int unsigned RECIP_MIN_SHIFT = 23;
  // Minutes of day (below 2^11) divided by 60.
  localparam logic [11:0] RECIP_HOUR = 12'd2185;
  localparam int unsigned RECIP_HOUR_SHIFT = 17;
  // Days within a century (below 2^16) divided by 1461.
  localparam logic [16:0] RECIP_4Y = 17'd91868;
  localparam int unsigned RECIP_4Y_SHIFT = 27;

  typedef logic [11:0] year_t;
  typedef logic [3:0]  month_t;
  typedef logic [4:0]  mday_t;
  typedef logic [4:0]  hour_t;
  typedef logic [5:0]  minsec_t;
  typedef logic [8:0]  doy_t;

  typedef struct packed {
    hour_t   hour;
    minsec_t minute;
    minsec_t second;
  } tod_t;

  localparam logic [4:0] MONTH_LEN [12] = '{
    5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  // Zero-based day of year on which month number idx (0 is January) begins.
  function automatic doy_t month_start(input month_t idx, input logic leap);
    doy_t sum;
    sum = '0;
    for (int i = 0; i < 12; i++) begin
      if (month_t'(i) < idx) begin
        sum = sum + doy_t'(MONTH_LEN[i]);
      end
    end
    if (leap && idx >= month_t'(2)) begin
      sum = sum + doy_t'(1);
    end
    return sum;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/escd_stamp_if.sv
// Input channel of the epoch-to-date converter: one timestamp per transaction.
// Stands alone; the width follows the converter's stamp width.
`default_nettype none

interface escd_stamp_if #(
  parameter int unsigned STAMP_WIDTH = 32
) ();
  logic                   valid;
  logic                   ready;
  logic [STAMP_WIDTH-1:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink (input valid, input epoch_seconds, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/escd_date_if.sv
// Output channel of the epoch-to-date converter: one calendar date and time per transaction.
// Depends on escd_pkg for the field types.
`default_nettype none

interface escd_date_if ();
  logic              valid;
  logic              ready;
  escd_pkg::year_t   year;
  escd_pkg::month_t  month;
  escd_pkg::mday_t   day_of_month;
  escd_pkg::hour_t   hour;
  escd_pkg::minsec_t minute;
  escd_pkg::minsec_t second;

  modport source (output valid, output year, output month, output day_of_month,
                  output hour, output minute, output second, input ready);
  modport sink (input valid, input year, input month, input day_of_month,
                input hour, input minute, input second, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/epoch_seconds_to_calendar_date.sv
// Top level of the Unix timestamp to Gregorian date and time converter.
// Depends on escd_pkg, escd_stamp_if, escd_date_if and escd_civil.
//
//   Channel    Dir  Payload                                              Handshake
//   stamp_in   in   epoch_seconds [STAMP_WIDTH]                           valid/ready
//   date_out   out  year, month, day_of_month, hour, minute, second       valid/ready
//
// Throughput is one transaction per cycle while date_out is ready; data passes through the eleven
// register stages of the day split, the 400/100/4/1-year cycle split and the month search.
// Reset (rst, synchronous) clears only the stage valid bits; data registers are not reset.
// Each stage has its own ready, so a stall at date_out holds the full stages and lets
// empty stages upstream keep filling; nothing is dropped or repeated.
`default_nettype none

module epoch_seconds_to_calendar_date #(
  parameter int unsigned STAMP_WIDTH = 32
) (
  input logic         clk,
  input logic         rst,
  escd_stamp_if.sink  stamp_in,
  escd_date_if.source date_out
);

  localparam int unsigned NS = 11;
  localparam int unsigned XW = STAMP_WIDTH - escd_pkg::DAY_SHIFT;
  localparam longint unsigned DAYS_MAX =
      ((64'd1 << STAMP_WIDTH) - 64'd1) / 64'(escd_pkg::SECS_PER_DAY);
  localparam int unsigned DW = $clog2(DAYS_MAX + 64'd1);
  localparam int unsigned NW = $clog2(DAYS_MAX + 64'(escd_pkg::DAYS_0001_TO_1970) + 64'd1);
  // Truncated reciprocal of 675: the estimate is the true quotient or one below it.
  localparam int unsigned K1 = XW;
  localparam int unsigned M1W = K1 - 9;
  localparam logic [M1W-1:0] M1 = M1W'((64'd1 << K1) / 64'(escd_pkg::DAY_ODD));

  logic [NS:1]   v;
  logic [NS:1]   v_up;
  logic [NS+1:1] rdy;

  // Stage 1: quotient estimate of the stamp divided by 86400.
  logic [XW+M1W-1:0] s0_prod;
  logic [XW-1:0]     s1_x;
  logic [DW-1:0]     s1_q;
  logic [6:0]        s1_lo;

  // Stage 2: remainder of the estimate.
  logic [XW-1:0] s1_rem;
  logic [DW-1:0] s2_q;
  logic [10:0]   s2_rem;
  logic [6:0]    s2_lo;

  // Stage 3: corrected day count, day number since 0001-01-01 and second of day.
  logic          s2_corr;
  logic [10:0]   s2_remc;
  logic [NW-1:0] s3_n;
  logic [16:0]   s3_secs;

  // Stages 4 to 6: minute of day, then hour and second, then minute.
  logic [34:0]       s3_mprod;
  logic [10:0]       s4_mday;
  logic [16:0]       s4_secs;
  logic [22:0]       s4_hprod;
  logic [16:0]       s4_sdiff;
  logic [10:0]       s5_mday;
  escd_pkg::hour_t   s5_hour;
  escd_pkg::minsec_t s5_second;
  logic [10:0]       s5_mdiff;
  escd_pkg::tod_t    s6_tod;
  escd_pkg::tod_t    tod_q [7:NS];

  // Flow control: a stage takes new contents when it is empty or its successor moves.
  always_comb begin
    rdy[NS+1] = date_out.ready;
    for (int i = NS; i >= 1; i--) begin
      rdy[i] = !v[i] || rdy[i+1];
    end
  end

  assign v_up = {v[NS-1:1], stamp_in.valid};

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 1; i <= NS; i++) begin
        if (rdy[i]) begin
          v[i] <= v_up[i];
        end
      end
    end
  end

  assign stamp_in.ready = rdy[1];
  assign date_out.valid = v[NS];

  assign s0_prod = stamp_in.epoch_seconds[STAMP_WIDTH-1:escd_pkg::DAY_SHIFT] * M1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_x  <= stamp_in.epoch_seconds[STAMP_WIDTH-1:escd_pkg::DAY_SHIFT];
      s1_q  <= DW'(s0_prod >> K1);
      s1_lo <= stamp_in.epoch_seconds[escd_pkg::DAY_SHIFT-1:0];
    end
  end

  assign s1_rem = s1_x - XW'(s1_q) * XW'(escd_pkg::DAY_ODD);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_q   <= s1_q;
      s2_rem <= s1_rem[10:0];
      s2_lo  <= s1_lo;
    end
  end

  always_comb begin
    s2_corr = s2_rem >= 11'(escd_pkg::DAY_ODD);
    s2_remc = s2_corr ? s2_rem - 11'(escd_pkg::DAY_ODD) : s2_rem;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_n    <= NW'(s2_q) + NW'(escd_pkg::DAYS_0001_TO_1970) + NW'(s2_corr);
      s3_secs <= {s2_remc[9:0], s2_lo};
    end
  end

  assign s3_mprod = s3_secs * escd_pkg::RECIP_MIN;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      s4_mday <= 11'(s3_mprod >> escd_pkg::RECIP_MIN_SHIFT);
      s4_secs <= s3_secs;
    end
  end

  assign s4_hprod = s4_mday * escd_pkg::RECIP_HOUR;
  assign s4_sdiff = s4_secs - 17'(s4_mday) * 17'(escd_pkg::SECS_PER_MIN);

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_mday   <= s4_mday;
      s5_hour   <= escd_pkg::hour_t'(s4_hprod >> escd_pkg::RECIP_HOUR_SHIFT);
      s5_second <= s4_sdiff[5:0];
    end
  end

  assign s5_mdiff = s5_mday - 11'(s5_hour) * 11'(escd_pkg::MIN_PER_HOUR);

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      s6_tod.hour   <= s5_hour;
      s6_tod.minute <= s5_mdiff[5:0];
      s6_tod.second <= s5_second;
    end
  end

  // Time of day waits alongside the date pipeline.
  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      tod_q[7] <= s6_tod;
    end
    for (int i = 8; i <= NS; i++) begin
      if (rdy[i]) begin
        tod_q[i] <= tod_q[i-1];
      end
    end
  end

  escd_civil #(
    .N_WIDTH (NW)
  ) u_civil (
    .clk          (clk),
    .en           (rdy[NS:4]),
    .day_num      (s3_n),
    .year         (date_out.year),
    .month        (date_out.month),
    .day_of_month (date_out.day_of_month)
  );

  assign date_out.hour   = tod_q[NS].hour;
  assign date_out.minute = tod_q[NS].minute;
  assign date_out.second = tod_q[NS].second;

`ifndef SYNTHESIS
  a_day_rem: assert property (@(posedge clk) disable iff (rst)
      v[2] |-> s2_rem < 11'(2 * escd_pkg::DAY_ODD))
    else $error("day quotient estimate is off by more than one");

  a_month: assert property (@(posedge clk) disable iff (rst)
      v[NS] |-> (date_out.month >= 4'd1) && (date_out.month <= 4'd12))
    else $error("month out of range");

  a_mday: assert property (@(posedge clk) disable iff (rst)
      v[NS] |-> (date_out.day_of_month != 5'd0))
    else $error("day of month is zero");

  a_tod: assert property (@(posedge clk) disable iff (rst)
      v[NS] |-> (date_out.hour < 5'd24) && (date_out.minute < 6'd60) &&
                (date_out.second < 6'd60))
    else $error("time of day out of range");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/escd_civil.sv
// Eight-stage pipeline from a day number since 0001-01-01 to year, month and day.
// Depends on escd_pkg; stage enables come from the top level's flow control.
`default_nettype none

module escd_civil #(
  parameter int unsigned N_WIDTH = 20
) (
  input  logic              clk,
  input  logic [7:0]        en,
  input  logic [N_WIDTH-1:0] day_num,
  output escd_pkg::year_t   year,
  output escd_pkg::month_t  month,
  output escd_pkg::mday_t   day_of_month
);

  localparam int unsigned K4 = N_WIDTH + 18;
  localparam int unsigned M4W = K4 - 17;
  localparam logic [M4W-1:0] M4 = M4W'(((64'd1 << K4) + 64'(escd_pkg::DAYS_PER_400Y) - 64'd1)
                                        / 64'(escd_pkg::DAYS_PER_400Y));
  localparam int unsigned QW =
      $clog2(((64'd1 << N_WIDTH) - 64'd1) / 64'(escd_pkg::DAYS_PER_400Y) + 64'd1);

  // Stage 1: number of whole 400-year cycles.
  logic [N_WIDTH+M4W-1:0] p0_prod;
  logic [QW-1:0]          c1_q400;
  logic [N_WIDTH-1:0]     c1_n;

  // Stage 2: days within the 400-year cycle.
  logic [N_WIDTH-1:0] c1_back;
  logic [N_WIDTH-1:0] c1_diff;
  logic [QW-1:0]      c2_q400;
  logic [17:0]        c2_r;

  // Stage 3: centuries, clamped so the last day of a cycle stays in the fourth century.
  logic [1:0]    c2_cent;
  logic [17:0]   c2_rem;
  logic [QW-1:0] c3_q400;
  logic [1:0]    c3_cent;
  logic [15:0]   c3_r;

  // Stage 4: four-year cycles within the century.
  logic [32:0]   c3_prod;
  logic [QW-1:0] c4_q400;
  logic [1:0]    c4_cent;
  logic [4:0]    c4_q4;
  logic [15:0]   c4_r;

  // Stage 5: days within the four-year cycle.
  logic [15:0]   c4_rem;
  logic [QW-1:0] c5_q400;
  logic [1:0]    c5_cent;
  logic [4:0]    c5_q4;
  logic [10:0]   c5_r;

  // Stage 6: year within the four-year cycle, day of year, leap flag and year number.
  logic [1:0]         c5_y1;
  logic [10:0]        c5_rem;
  escd_pkg::year_t    c6_year;
  escd_pkg::doy_t     c6_doy;
  logic               c6_leap;

  // Stage 7: month index by comparing against every month start after January in parallel.
  escd_pkg::month_t c6_idx;
  escd_pkg::year_t  c7_year;
  escd_pkg::doy_t   c7_doy;
  logic             c7_leap;
  escd_pkg::month_t c7_idx;

  // Stage 8: day within the month.
  escd_pkg::doy_t c7_dom;

  assign p0_prod = day_num * M4;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      c1_q400 <= QW'(p0_prod >> K4);
      c1_n    <= day_num;
    end
  end

  assign c1_back = N_WIDTH'(c1_q400) * N_WIDTH'(escd_pkg::DAYS_PER_400Y);
  assign c1_diff = c1_n - c1_back;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      c2_q400 <= c1_q400;
      c2_r    <= c1_diff[17:0];
    end
  end

  always_comb begin
    c2_cent = 2'(c2_r >= 18'(escd_pkg::DAYS_PER_100Y))
            + 2'(c2_r >= 18'(2 * escd_pkg::DAYS_PER_100Y))
            + 2'(c2_r >= 18'(3 * escd_pkg::DAYS_PER_100Y));
    c2_rem  = c2_r - 18'(c2_cent) * 18'(escd_pkg::DAYS_PER_100Y);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      c3_q400 <= c2_q400;
      c3_cent <= c2_cent;
      c3_r    <= c2_rem[15:0];
    end
  end

  assign c3_prod = c3_r * escd_pkg::RECIP_4Y;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      c4_q400 <= c3_q400;
      c4_cent <= c3_cent;
      c4_q4   <= 5'(c3_prod >> escd_pkg::RECIP_4Y_SHIFT);
      c4_r    <= c3_r;
    end
  end

  assign c4_rem = c4_r - 16'(c4_q4) * 16'(escd_pkg::DAYS_PER_4Y);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      c5_q400 <= c4_q400;
      c5_cent <= c4_cent;
      c5_q4   <= c4_q4;
      c5_r    <= c4_rem[10:0];
    end
  end

  // The last day of a four-year cycle belongs to its fourth year, hence the clamp at three.
  always_comb begin
    c5_y1  = 2'(c5_r >= 11'(escd_pkg::DAYS_PER_YEAR))
           + 2'(c5_r >= 11'(2 * escd_pkg::DAYS_PER_YEAR))
           + 2'(c5_r >= 11'(3 * escd_pkg::DAYS_PER_YEAR));
    c5_rem = c5_r - 11'(c5_y1) * 11'(escd_pkg::DAYS_PER_YEAR);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      c6_year <= escd_pkg::year_t'(1)
               + escd_pkg::year_t'(c5_q400) * escd_pkg::year_t'(escd_pkg::YEARS_PER_400Y)
               + escd_pkg::year_t'(c5_cent) * escd_pkg::year_t'(escd_pkg::YEARS_PER_100Y)
               + escd_pkg::year_t'(c5_q4) * escd_pkg::year_t'(escd_pkg::YEARS_PER_4Y)
               + escd_pkg::year_t'(c5_y1);
      c6_doy  <= c5_rem[8:0];
      // A century year is a leap year only as the last century of a 400-year cycle.
      c6_leap <= (c5_y1 == 2'd3) &&
                 ((c5_q4 != 5'(escd_pkg::CENTURY_IN_4Y)) || (c5_cent == 2'd3));
    end
  end

  always_comb begin
    c6_idx = '0;
    for (int i = 1; i < 12; i++) begin
      c6_idx = c6_idx + escd_pkg::month_t'(
          c6_doy >= escd_pkg::month_start(escd_pkg::month_t'(i), c6_leap));
    end
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      c7_year <= c6_year;
      c7_doy  <= c6_doy;
      c7_leap <= c6_leap;
      c7_idx  <= c6_idx;
    end
  end

  assign c7_dom = c7_doy - escd_pkg::month_start(c7_idx, c7_leap);

  always_ff @(posedge clk) begin
    if (en[7]) begin
      year         <= c7_year;
      month        <= c7_idx + escd_pkg::month_t'(1);
      day_of_month <= c7_dom[4:0] + escd_pkg::mday_t'(1);
    end
  end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for the Unix timestamp to calendar date converter.
// Depends on escd_pkg, escd_stamp_if, escd_date_if and the converter's top level.

module testbench;

  typedef struct packed {
    escd_pkg::year_t   year;
    escd_pkg::month_t  month;
    escd_pkg::mday_t   day_of_month;
    escd_pkg::hour_t   hour;
    escd_pkg::minsec_t minute;
    escd_pkg::minsec_t second;
  } calendar_t;

  // A row with known set carries its own expected date; the others go through the predictor.
  typedef struct packed {
    logic [31:0] stamp;
    bit          known;
    calendar_t   date;
  } directed_row_t;

  localparam longint unsigned DAY_SECONDS = 86400;
  localparam longint unsigned DAYS_BEFORE_EPOCH = 719162;
  localparam longint unsigned ERA_DAYS = 146097;
  localparam longint unsigned CENTURY_DAYS = 36524;
  localparam longint unsigned QUAD_DAYS = 1461;
  localparam longint unsigned PLAIN_YEAR_DAYS = 365;
  localparam longint unsigned LEAPS_THROUGH_1969 = 477;
  localparam longint unsigned LAST_WHOLE_DAY = 49709;
  localparam int unsigned MONTH_LENGTHS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

  localparam int NUM_DIRECTED = 18;
  localparam int RANDOM_PER_PHASE = 483;
  localparam int NUM_PHASES = 4;
  localparam int SETTLE_CYCLES = 25;

  localparam directed_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{32'd0,          1'b1, '{12'd1970, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd86399,      1'b1, '{12'd1970, 4'd1,  5'd1,  5'd23, 6'd59, 6'd59}},
    '{32'd86400,      1'b1, '{12'd1970, 4'd1,  5'd2,  5'd0,  6'd0,  6'd0}},
    '{32'd68169600,   1'b0, '0},
    '{32'd94694399,   1'b0, '0},
    '{32'd126230399,  1'b1, '{12'd1973, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'd946684799,  1'b1, '{12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'd946684800,  1'b1, '{12'd2000, 4'd1,  5'd1,  5'd0,  6'd0,  6'd0}},
    '{32'd951782400,  1'b1, '{12'd2000, 4'd2,  5'd29, 5'd0,  6'd0,  6'd0}},
    '{32'd951868800,  1'b0, '0},
    '{32'd2147483647, 1'b1, '{12'd2038, 4'd1,  5'd19, 5'd3,  6'd14, 6'd7}},
    '{32'd2147483648, 1'b0, '0},
    '{32'hAAAAAAAA,   1'b0, '0},
    '{32'h55555555,   1'b0, '0},
    '{32'd4107542399, 1'b0, '0},
    '{32'd4107542400, 1'b0, '0},
    '{32'd4291747199, 1'b1, '{12'd2105, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59}},
    '{32'hFFFFFFFF,   1'b1, '{12'd2106, 4'd2,  5'd7,  5'd6,  6'd28, 6'd15}}
  };

  localparam int SENDER_IDLE_PCT [NUM_PHASES] = '{0, 54, 0, 22};
  localparam int RECEIVER_STALL_PCT [NUM_PHASES] = '{0, 0, 54, 22};

  logic clk;
  logic rst;

  escd_stamp_if #(.STAMP_WIDTH(32)) stamp_ch ();
  escd_date_if date_ch ();

  epoch_seconds_to_calendar_date #(.STAMP_WIDTH(32)) dut (
    .clk      (clk),
    .rst      (rst),
    .stamp_in (stamp_ch),
    .date_out (date_ch)
  );

  calendar_t pending_dates [$];
  calendar_t oldest_date;
  int        mismatch_count = 0;
  int        sender_idle_pct = 0;
  int        receiver_stall_pct = 0;

  initial begin
    clk = 1'b0;
  end

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Splits whole days into 400-, 100-, 4- and 1-year cycles counted from year 1.
  function automatic calendar_t civil_date_of(input logic [31:0] stamp);
    longint unsigned seconds;
    longint unsigned sec_of_day;
    longint unsigned day_num;
    longint unsigned eras;
    longint unsigned cents;
    longint unsigned quads;
    longint unsigned odd_years;
    longint unsigned rest;
    longint unsigned yr;
    longint unsigned len;
    int unsigned     mon;
    bit              leap;
    bit              found;
    calendar_t       d;
    seconds = stamp;
    sec_of_day = seconds % DAY_SECONDS;
    day_num = seconds / DAY_SECONDS + DAYS_BEFORE_EPOCH;
    eras = day_num / ERA_DAYS;
    rest = day_num % ERA_DAYS;
    cents = rest / CENTURY_DAYS;
    if (cents > 3) begin
      cents = 3;
    end
    rest = rest - cents * CENTURY_DAYS;
    quads = rest / QUAD_DAYS;
    rest = rest % QUAD_DAYS;
    odd_years = rest / PLAIN_YEAR_DAYS;
    if (odd_years > 3) begin
      odd_years = 3;
    end
    rest = rest - odd_years * PLAIN_YEAR_DAYS;
    yr = 1 + 400 * eras + 100 * cents + 4 * quads + odd_years;
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    mon = 12;
    found = 1'b0;
    for (int i = 0; i < 12; i++) begin
      len = MONTH_LENGTHS[i];
      if (i == 1 && leap) begin
        len = 29;
      end
      if (!found) begin
        if (rest < len) begin
          mon = i + 1;
          found = 1'b1;
        end else begin
          rest = rest - len;
        end
      end
    end
    d.year = escd_pkg::year_t'(yr);
    d.month = escd_pkg::month_t'(mon);
    d.day_of_month = escd_pkg::mday_t'(rest + 1);
    d.hour = escd_pkg::hour_t'(sec_of_day / 3600);
    d.minute = escd_pkg::minsec_t'((sec_of_day / 60) % 60);
    d.second = escd_pkg::minsec_t'(sec_of_day % 60);
    return d;
  endfunction

  // Uniform stamps, whole-day edges, and instants around a New Year.
  function automatic logic [31:0] random_stamp();
    longint unsigned base;
    longint unsigned yr;
    longint unsigned leaps;
    logic [31:0]     s;
    s = $urandom;
    case ($urandom_range(3))
      2: begin
        base = longint'($urandom_range(32'(LAST_WHOLE_DAY))) * DAY_SECONDS;
        case ($urandom_range(2))
          0: s = 32'(base);
          1: s = 32'(base + DAY_SECONDS - 1);
          default: s = 32'(base + $urandom_range(32'(DAY_SECONDS - 1)));
        endcase
      end
      3: begin
        yr = $urandom_range(2106, 1971);
        leaps = (yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 - LEAPS_THROUGH_1969;
        base = (PLAIN_YEAR_DAYS * (yr - 1970) + leaps) * DAY_SECONDS
               + $urandom_range(32'(4 * DAY_SECONDS)) - 2 * DAY_SECONDS;
        if (base > 64'hFFFFFFFF) begin
          base = 64'hFFFFFFFF;
        end
        s = 32'(base);
      end
      default: begin
      end
    endcase
    return s;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // Called just after a falling edge; returns just after the falling edge that
  // follows the transaction.
  task automatic send_stamp(input logic [31:0] stamp, input calendar_t want);
    while ($urandom_range(99) < sender_idle_pct) begin
      stamp_ch.valid <= 1'b0;
      @(negedge clk);
    end
    stamp_ch.valid <= 1'b1;
    stamp_ch.epoch_seconds <= stamp;
    @(posedge clk);
    while (!stamp_ch.ready) begin
      @(posedge clk);
    end
    pending_dates.push_back(want);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    date_ch.ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && date_ch.valid === 1'b1 && date_ch.ready === 1'b1) begin
      if (pending_dates.size() == 0) begin
        flag_mismatch("date transaction with none outstanding");
      end else begin
        oldest_date = pending_dates.pop_front();
        if (date_ch.year !== oldest_date.year)
          flag_mismatch($sformatf("year %0d, expected %0d", date_ch.year, oldest_date.year));
        if (date_ch.month !== oldest_date.month)
          flag_mismatch($sformatf("month %0d, expected %0d", date_ch.month, oldest_date.month));
        if (date_ch.day_of_month !== oldest_date.day_of_month)
          flag_mismatch($sformatf("day_of_month %0d, expected %0d",
                                  date_ch.day_of_month, oldest_date.day_of_month));
        if (date_ch.hour !== oldest_date.hour)
          flag_mismatch($sformatf("hour %0d, expected %0d", date_ch.hour, oldest_date.hour));
        if (date_ch.minute !== oldest_date.minute)
          flag_mismatch($sformatf("minute %0d, expected %0d",
                                  date_ch.minute, oldest_date.minute));
        if (date_ch.second !== oldest_date.second)
          flag_mismatch($sformatf("second %0d, expected %0d",
                                  date_ch.second, oldest_date.second));
      end
    end
  end

  initial begin
    logic [31:0] stamp;
    rst = 1'b1;
    stamp_ch.valid = 1'b0;
    stamp_ch.epoch_seconds = '0;
    date_ch.ready = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < NUM_DIRECTED; i++) begin
      send_stamp(DIRECTED_ROWS[i].stamp,
                 DIRECTED_ROWS[i].known ? DIRECTED_ROWS[i].date
                                        : civil_date_of(DIRECTED_ROWS[i].stamp));
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      sender_idle_pct = SENDER_IDLE_PCT[p];
      receiver_stall_pct = RECEIVER_STALL_PCT[p];
      repeat (RANDOM_PER_PHASE) begin
        stamp = random_stamp();
        send_stamp(stamp, civil_date_of(stamp));
      end
      // Hold off the next phase until the pipeline has drained completely.
      stamp_ch.valid <= 1'b0;
      while (pending_dates.size() != 0) begin
        @(negedge clk);
      end
    end

    receiver_stall_pct = 0;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_dates.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
